// File: rtl/sss_pkg.sv
// Shared types, request codes and reset constants for the stepper segment sequencer.
// No dependencies; every other file in rtl/ imports this package.
package sss_pkg;

    // Default sizing handed to the top level parameters
    localparam int MAX_SEGMENTS_DEF   = 16;
    localparam int TICKS_PER_UNIT_DEF = 2;

    // Request kinds carried in s_tuser
    localparam logic [2:0] REQ_TICK   = 3'd0;
    localparam logic [2:0] REQ_LOAD   = 3'd1;
    localparam logic [2:0] REQ_START  = 3'd2;
    localparam logic [2:0] REQ_PAUSE  = 3'd3;
    localparam logic [2:0] REQ_TOGGLE = 3'd4;
    localparam logic [2:0] REQ_CLEAR  = 3'd5;

    // Segment direction codes
    localparam logic [1:0] DIR_IN   = 2'd0;
    localparam logic [1:0] DIR_OUT  = 2'd1;
    localparam logic [1:0] DIR_AUTO = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_TRACK_COUNT = 2'd0;
    localparam logic [1:0] REG_SEQ_LENGTH  = 2'd1;
    localparam logic [1:0] REG_LOOP_ENABLE = 2'd2;
    localparam logic [1:0] REG_TEST_MODE   = 2'd3;

    localparam logic [7:0] TRACK_COUNT_RST = 8'd80;
    localparam logic [7:0] POSITION_MAX    = 8'd255;

    typedef struct packed {
        logic [15:0] steps;
        logic [15:0] high_time;
        logic [15:0] low_time;
        logic [1:0]  direction;
        logic        spindle_en;
    } seg_t;

    typedef struct packed {
        logic [7:0] track_count;
        logic [4:0] sequence_length;
        logic       loop_enable;
        logic       test_mode;
    } cfg_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       track0_low;
        logic [3:0] seg_index;
        seg_t       seg;
    } item_t;

    typedef struct packed {
        logic       step_level;
        logic       direction_level;
        logic       motor_enable_n;
        logic       error_light;
        logic       is_running;
        logic [7:0] head_position;
        logic       min_limit_hit;
        logic       max_limit_hit;
        logic       test_finished;
        logic [4:0] current_segment;
    } result_t;

endpackage

// File: rtl/sss_cfg.sv
// APB configuration registers: track count, sequence length, loop and test mode.
// Depends on sss_pkg.
module sss_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output sss_pkg::cfg_t       cfg
);
    import sss_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    // Decode a register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                REG_TRACK_COUNT: cfg_next.track_count     = pwdata[7:0];
                REG_SEQ_LENGTH:  cfg_next.sequence_length = pwdata[4:0];
                REG_LOOP_ENABLE: cfg_next.loop_enable     = pwdata[0];
                REG_TEST_MODE:   cfg_next.test_mode       = pwdata[0];
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_index)
            REG_TRACK_COUNT: prdata = {24'd0, cfg_reg.track_count};
            REG_SEQ_LENGTH:  prdata = {27'd0, cfg_reg.sequence_length};
            REG_LOOP_ENABLE: prdata = {31'd0, cfg_reg.loop_enable};
            REG_TEST_MODE:   prdata = {31'd0, cfg_reg.test_mode};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.track_count     <= TRACK_COUNT_RST;
            cfg_reg.sequence_length <= 5'd0;
            cfg_reg.loop_enable     <= 1'b0;
            cfg_reg.test_mode       <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/sss_seg_mem.sv
// Segment table: one write port, two registered read ports with write bypass.
// Depends on sss_pkg.
module sss_seg_mem #(
    parameter int DEPTH = sss_pkg::MAX_SEGMENTS_DEF,
    parameter int AW    = 4
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  sss_pkg::seg_t       wr_data,
    input  logic [AW-1:0]       rd_addr_a,
    input  logic [AW-1:0]       rd_addr_b,
    output sss_pkg::seg_t       rd_data_a,
    output logic                rd_motor_b
);
    import sss_pkg::*;

    seg_t mem [DEPTH];
    seg_t rd_a_reg;
    logic rd_b_reg;

    assign rd_data_a  = rd_a_reg;
    assign rd_motor_b = rd_b_reg;

    // Write, then read with new data forwarded on an address match
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr_a))
        begin
            rd_a_reg <= wr_data;
        end
        else
        begin
            rd_a_reg <= mem[rd_addr_a];
        end
        if (wr_en && (wr_addr == rd_addr_b))
        begin
            rd_b_reg <= wr_data.spindle_en;
        end
        else
        begin
            rd_b_reg <= mem[rd_addr_b].spindle_en;
        end
    end

endmodule

// File: rtl/sss_core.sv
// Step engine: playback state, pulse timing, head tracking and limit checks.
// Depends on sss_pkg; reads the segment table through sss_seg_mem ports.
module sss_core #(
    parameter int MAX_SEGMENTS   = sss_pkg::MAX_SEGMENTS_DEF,
    parameter int TICKS_PER_UNIT = sss_pkg::TICKS_PER_UNIT_DEF,
    parameter int AW             = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  sss_pkg::item_t      item,
    input  sss_pkg::cfg_t       cfg,
    input  sss_pkg::seg_t       cur_seg,
    input  logic                nxt_motor,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output sss_pkg::seg_t       wr_data,
    output logic [AW-1:0]       rd_addr_a,
    output logic [AW-1:0]       rd_addr_b,
    output sss_pkg::result_t    result
);
    import sss_pkg::*;

    localparam int POS_W = $clog2(MAX_SEGMENTS + 1);
    localparam int TCK_W = 17 + $clog2(TICKS_PER_UNIT);

    logic             running_reg,  running_next;
    logic             phase_reg,    phase_next;
    logic [TCK_W-1:0] tick_reg,     tick_next;
    logic [16:0]      step_cnt_reg, step_cnt_next;
    logic [POS_W-1:0] seg_pos_reg,  seg_pos_next;
    logic             pend_reg,     pend_next;
    logic [7:0]       position_reg, position_next;
    logic             auto_out_reg, auto_out_next;
    logic             min_reg,      min_next;
    logic             max_reg,      max_next;
    logic             done_reg,     done_next;
    logic             pin_step_reg, pin_step_next;
    logic             pin_dir_reg,  pin_dir_next;
    logic             pin_mot_reg,  pin_mot_next;
    logic             pin_err_reg,  pin_err_next;
    logic             motor0_reg,   motor0_next;

    logic [POS_W-1:0] len_eff;
    logic [POS_W-1:0] seg_pos_inc;
    logic [POS_W-1:0] rd_pos_b;
    logic [TCK_W-1:0] tick_inc;
    logic [TCK_W-1:0] low_thr;
    logic [TCK_W-1:0] high_thr;
    logic [16:0]      step_inc;
    logic             load_ok;

    // Effective table length, clamped to the table size
    assign len_eff = (int'(cfg.sequence_length) < MAX_SEGMENTS) ?
                     POS_W'(cfg.sequence_length) : POS_W'(MAX_SEGMENTS);

    assign seg_pos_inc = seg_pos_reg + POS_W'(1);
    assign tick_inc    = tick_reg + TCK_W'(1);
    assign step_inc    = step_cnt_reg + 17'd1;
    assign low_thr     = TCK_W'(cur_seg.low_time)  * TCK_W'(TICKS_PER_UNIT);
    assign high_thr    = TCK_W'(cur_seg.high_time) * TCK_W'(TICKS_PER_UNIT);

    // Table write for a load request
    assign load_ok = accept && (item.req_type == REQ_LOAD) &&
                     (int'(item.seg_index) < MAX_SEGMENTS);
    assign wr_en   = load_ok;
    assign wr_addr = AW'(item.seg_index);
    assign wr_data = item.seg;

    // Prefetch the segment at the next position and the motor bit after it
    assign rd_pos_b  = seg_pos_next + POS_W'(1);
    assign rd_addr_a = seg_pos_next[AW-1:0];
    assign rd_addr_b = rd_pos_b[AW-1:0];

    always_comb
    begin
        logic end_seq;
        end_seq       = 1'b0;
        running_next  = running_reg;
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        step_cnt_next = step_cnt_reg;
        seg_pos_next  = seg_pos_reg;
        pend_next     = pend_reg;
        position_next = position_reg;
        auto_out_next = auto_out_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        done_next     = done_reg;
        pin_step_next = pin_step_reg;
        pin_dir_next  = pin_dir_reg;
        pin_mot_next  = pin_mot_reg;
        pin_err_next  = pin_err_reg;
        motor0_next   = motor0_reg;

        if (load_ok && (item.seg_index == 4'd0))
        begin
            motor0_next = item.seg.spindle_en;
        end

        if (accept)
        begin
            unique case (item.req_type)
                REQ_TICK:
                begin
                    if (running_reg)
                    begin
                        if (seg_pos_reg >= len_eff)
                        begin
                            end_seq = 1'b1;
                        end
                        else if (!phase_reg)
                        begin
                            tick_next = tick_inc;
                            if ((tick_inc >= low_thr) || pend_reg)
                            begin
                                pend_next = 1'b0;
                                if (step_inc > {1'b0, cur_seg.steps})
                                begin
                                    // Segment done: move on
                                    step_cnt_next = 17'd0;
                                    seg_pos_next  = seg_pos_inc;
                                    if (seg_pos_inc < len_eff)
                                    begin
                                        pend_next    = 1'b1;
                                        pin_mot_next = !nxt_motor;
                                    end
                                    else
                                    begin
                                        end_seq = 1'b1;
                                    end
                                end
                                else
                                begin
                                    step_cnt_next = step_inc;
                                    if (cur_seg.high_time != 16'd0)
                                    begin
                                        // Start a pulse, with a limit check on inward and outward steps
                                        unique case (cur_seg.direction)
                                            DIR_IN:
                                            begin
                                                pin_dir_next = 1'b0;
                                                if (position_reg >= cfg.track_count)
                                                begin
                                                    max_next     = 1'b1;
                                                    phase_next   = 1'b0;
                                                    running_next = 1'b0;
                                                    pin_err_next = 1'b1;
                                                    done_next    = 1'b1;
                                                end
                                                else
                                                begin
                                                    position_next = position_reg + 8'd1;
                                                    phase_next    = 1'b1;
                                                    pin_step_next = 1'b0;
                                                end
                                            end
                                            DIR_OUT:
                                            begin
                                                pin_dir_next = 1'b1;
                                                if ((position_reg == 8'd0) || item.track0_low)
                                                begin
                                                    min_next     = 1'b1;
                                                    phase_next   = 1'b0;
                                                    running_next = 1'b0;
                                                    pin_err_next = 1'b1;
                                                    done_next    = 1'b1;
                                                end
                                                else
                                                begin
                                                    position_next = position_reg - 8'd1;
                                                    phase_next    = 1'b1;
                                                    pin_step_next = 1'b0;
                                                end
                                            end
                                            DIR_AUTO:
                                            begin
                                                // Bounce between zero and the track count
                                                if (position_reg >= cfg.track_count)
                                                begin
                                                    auto_out_next = 1'b1;
                                                    pin_dir_next  = 1'b1;
                                                end
                                                else if (position_reg == 8'd0)
                                                begin
                                                    auto_out_next = 1'b0;
                                                    pin_dir_next  = 1'b0;
                                                end
                                                if (auto_out_next)
                                                begin
                                                    if (position_reg != 8'd0)
                                                    begin
                                                        position_next = position_reg - 8'd1;
                                                    end
                                                end
                                                else if (position_reg != POSITION_MAX)
                                                begin
                                                    position_next = position_reg + 8'd1;
                                                end
                                                phase_next    = 1'b1;
                                                pin_step_next = 1'b0;
                                                if (item.track0_low && !cfg.test_mode)
                                                begin
                                                    position_next = 8'd0;
                                                end
                                            end
                                            default:
                                            begin
                                                // Unused direction code: count only
                                            end
                                        endcase
                                    end
                                end
                                tick_next = '0;
                            end
                        end
                        else
                        begin
                            tick_next = tick_inc;
                            if (tick_inc >= high_thr)
                            begin
                                // End of active phase
                                if (cur_seg.low_time != 16'd0)
                                begin
                                    pin_step_next = 1'b1;
                                end
                                phase_next = 1'b0;
                                tick_next  = '0;
                            end
                        end
                    end
                end
                REQ_LOAD:
                begin
                    // Table write only
                end
                REQ_START:
                begin
                    if (!done_reg && (len_eff != '0))
                    begin
                        if (cfg.test_mode)
                        begin
                            position_next = 8'd0;
                            auto_out_next = 1'b0;
                            pin_step_next = 1'b1;
                            pin_dir_next  = 1'b1;
                        end
                        seg_pos_next  = '0;
                        pend_next     = 1'b1;
                        phase_next    = 1'b0;
                        tick_next     = '0;
                        step_cnt_next = 17'd0;
                        pin_err_next  = 1'b0;
                        pin_mot_next  = !motor0_reg;
                        running_next  = 1'b1;
                    end
                end
                REQ_PAUSE:
                begin
                    running_next = 1'b0;
                end
                REQ_TOGGLE:
                begin
                    if (!cfg.test_mode && (len_eff != '0) && (running_reg || !done_reg))
                    begin
                        running_next = !running_reg;
                    end
                end
                REQ_CLEAR:
                begin
                    if (done_reg)
                    begin
                        running_next  = 1'b0;
                        pin_dir_next  = 1'b1;
                        pin_step_next = 1'b1;
                        pin_err_next  = min_reg || max_reg;
                        seg_pos_next  = '0;
                        pend_next     = 1'b1;
                        phase_next    = 1'b0;
                        tick_next     = '0;
                        position_next = 8'd0;
                        step_cnt_next = 17'd0;
                        auto_out_next = 1'b0;
                        min_next      = 1'b0;
                        max_next      = 1'b0;
                        done_next     = 1'b0;
                    end
                end
                default:
                begin
                    // Undefined request kinds: no effect
                end
            endcase

            // End of sequence: loop, flag test completion, or stop
            if (end_seq)
            begin
                if (cfg.loop_enable)
                begin
                    seg_pos_next = '0;
                    pend_next    = 1'b1;
                    phase_next   = 1'b0;
                    tick_next    = '0;
                    running_next = 1'b1;
                end
                else if (cfg.test_mode)
                begin
                    done_next    = 1'b1;
                    running_next = 1'b0;
                end
                else
                begin
                    running_next = 1'b0;
                    seg_pos_next = '0;
                    pend_next    = 1'b1;
                    phase_next   = 1'b0;
                    tick_next    = '0;
                end
            end
        end
    end

    // Result reflects the state after the request
    always_comb
    begin
        result.step_level      = pin_step_next;
        result.direction_level = pin_dir_next;
        result.motor_enable_n  = pin_mot_next;
        result.error_light     = pin_err_next;
        result.is_running      = running_next;
        result.head_position   = position_next;
        result.min_limit_hit   = min_next;
        result.max_limit_hit   = max_next;
        result.test_finished   = done_next;
        result.current_segment = 5'(seg_pos_next);
    end

    always_ff @(posedge clk)
    begin
        motor0_reg <= motor0_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg  <= 1'b0;
            phase_reg    <= 1'b0;
            tick_reg     <= '0;
            step_cnt_reg <= 17'd0;
            seg_pos_reg  <= '0;
            pend_reg     <= 1'b1;
            position_reg <= 8'd0;
            auto_out_reg <= 1'b0;
            min_reg      <= 1'b0;
            max_reg      <= 1'b0;
            done_reg     <= 1'b0;
            pin_step_reg <= 1'b1;
            pin_dir_reg  <= 1'b1;
            pin_mot_reg  <= 1'b1;
            pin_err_reg  <= 1'b0;
        end
        else
        begin
            running_reg  <= running_next;
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            step_cnt_reg <= step_cnt_next;
            seg_pos_reg  <= seg_pos_next;
            pend_reg     <= pend_next;
            position_reg <= position_next;
            auto_out_reg <= auto_out_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            done_reg     <= done_next;
            pin_step_reg <= pin_step_next;
            pin_dir_reg  <= pin_dir_next;
            pin_mot_reg  <= pin_mot_next;
            pin_err_reg  <= pin_err_next;
        end
    end

endmodule

// File: rtl/sss_out_buf.sv
// Two-entry result buffer between the step engine and the master stream side.
// Depends on sss_pkg.
module sss_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sss_pkg::result_t    push_data,
    output logic                has_room,
    output logic                out_valid,
    input  logic                out_ready,
    output sss_pkg::result_t    out_data
);
    import sss_pkg::*;

    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign has_room  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot0_reg;
    assign pop       = out_valid && out_ready;

    // Queue control: slot 0 always heads the queue
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        unique case ({pop, push})
            2'b01:
            begin
                if (count_reg == 2'd0)
                begin
                    slot0_next = push_data;
                end
                else
                begin
                    slot1_next = push_data;
                end
                count_next = count_reg + 2'd1;
            end
            2'b10:
            begin
                slot0_next = slot1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    slot0_next = push_data;
                end
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = push_data;
                end
            end
            default:
            begin
                // Hold
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/stepper_segment_sequencer.sv
// Top level of the stepper segment sequencer: stream ports, APB registers, wiring.
// Depends on sss_pkg, sss_cfg, sss_seg_mem, sss_core and sss_out_buf.
//
//  Channel   Direction  Handshake            Content
//  s_*       in         s_tvalid / s_tready  one request: tick, segment load or command
//  m_*       out        m_tvalid / m_tready  one status word per request
//  apb       in/out     psel penable pready  track count, length, loop, test mode
//
// Every request is handled in the cycle it is accepted; its status word enters a
// two-entry output buffer, behind any earlier words; one request per clock while there
// is room. s_tready drops only while both buffer entries hold untaken status words.
// The segment table has registered reads, prefetched from the next position.
// Reset clears all control and playback state; the segment table holds no reset.
module stepper_segment_sequencer #(
    parameter int MAX_SEGMENTS   = sss_pkg::MAX_SEGMENTS_DEF,
    parameter int TICKS_PER_UNIT = sss_pkg::TICKS_PER_UNIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // track0_low[0], seg_index[4:1], seg_steps[20:5], seg_high_time[36:21],
    // seg_low_time[52:37], seg_direction[54:53], segment motor enable[55]
    input  logic [55:0] s_tdata,
    // req_type[2:0]
    input  logic [2:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // step_level[0], direction_level[1], motor_enable_n[2], error_light[3],
    // is_running[4], head_position[12:5], min_limit_hit[13], max_limit_hit[14],
    // test_finished[15], current_segment[20:16], zero fill[23:21]
    output logic [23:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sss_pkg::*;

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    cfg_t          cfg;
    item_t         item;
    seg_t          cur_seg;
    seg_t          wr_data;
    result_t       result;
    result_t       out_res;
    logic          accept;
    logic          nxt_motor;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;

    // Unpack the request
    always_comb
    begin
        item.req_type          = s_tuser;
        item.track0_low        = s_tdata[0];
        item.seg_index         = s_tdata[4:1];
        item.seg.steps         = s_tdata[20:5];
        item.seg.high_time     = s_tdata[36:21];
        item.seg.low_time      = s_tdata[52:37];
        item.seg.direction     = s_tdata[54:53];
        item.seg.spindle_en    = s_tdata[55];
    end

    assign accept = s_tvalid && s_tready;

    sss_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sss_seg_mem #(
        .DEPTH (MAX_SEGMENTS),
        .AW    (AW)
    ) u_seg_mem (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b),
        .rd_data_a  (cur_seg),
        .rd_motor_b (nxt_motor)
    );

    sss_core #(
        .MAX_SEGMENTS   (MAX_SEGMENTS),
        .TICKS_PER_UNIT (TICKS_PER_UNIT),
        .AW             (AW)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg       (cfg),
        .cur_seg   (cur_seg),
        .nxt_motor (nxt_motor),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .result    (result)
    );

    sss_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .has_room  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Pack the status word
    assign m_tdata = {3'd0,
                      out_res.current_segment,
                      out_res.test_finished,
                      out_res.max_limit_hit,
                      out_res.min_limit_hit,
                      out_res.head_position,
                      out_res.is_running,
                      out_res.error_light,
                      out_res.motor_enable_n,
                      out_res.direction_level,
                      out_res.step_level};

endmodule

// File: dv/stepper_segment_sequencer_test.sv
// Self-checking testbench for stepper_segment_sequencer: a directed request table, then
// random phases under changing register settings, every status word checked in order.
// Depends on rtl/sss_pkg.sv and rtl/stepper_segment_sequencer.sv.
module stepper_segment_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sss_pkg::*;

    localparam int MAX_SEGS       = MAX_SEGMENTS_DEF;
    localparam int TICKS          = TICKS_PER_UNIT_DEF;
    localparam int PHASES         = 8;
    localparam int PHASE_REQUESTS = 117;
    localparam int LONG_HOLD      = 150;
    localparam int QUIET_LIMIT    = 4000;
    localparam int REPORT_MAX     = 10;

    // Request kinds the block ignores, and the direction code that never pulses
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;
    localparam logic [1:0] DIR_NONE    = 2'd3;

    localparam result_t RESET_STATUS =
        '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 5'd0};

    typedef struct {
        item_t   req;
        bit      pinned;
        result_t status;
    } row_t;

    typedef struct {
        bit      fixed;
        result_t status;
    } pin_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic [55:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    stepper_segment_sequencer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 clk = ~clk;

    // Predictor state: segment table, registers and playback
    seg_t seg_plan [MAX_SEGS];
    cfg_t cfg;
    bit   play_on, pulse_high, advance_due, bounce_out;
    bit   hit_min, hit_max, run_done;
    bit   step_pin, dir_pin, motor_pin, err_pin;
    int   tick_cnt, step_cnt, seg_pos, head_pos;

    // Scoreboard and run statistics
    result_t status_due [$];
    pin_t    pinned_q [$];
    row_t    boot_rows [$];
    row_t    play_rows [$];
    int      fault_count, requests_in, words_out, reg_writes;
    int      limit_stops, completions;
    int      tx_gap_pct, rx_gap_pct;
    bit      long_hold_req;

    function automatic int active_len();
        return (cfg.sequence_length < MAX_SEGS) ? int'(cfg.sequence_length) : MAX_SEGS;
    endfunction

    function automatic void rewind_play();
        seg_pos     = 0;
        advance_due = 1'b1;
        pulse_high  = 1'b0;
        tick_cnt    = 0;
    endfunction

    // Loop, flag test completion, or stop at the end of the table
    function automatic void end_of_pass();
        if (cfg.loop_enable) begin
            rewind_play();
            play_on = 1'b1;
        end else if (cfg.test_mode) begin
            run_done = 1'b1;
            play_on  = 1'b0;
            completions++;
        end else begin
            play_on = 1'b0;
            rewind_play();
        end
    endfunction

    function automatic void limit_halt();
        pulse_high = 1'b0;
        play_on    = 1'b0;
        err_pin    = 1'b1;
        run_done   = 1'b1;
        limit_stops++;
    endfunction

    // Start one step pulse, moving the head or stopping at a limit
    function automatic void fire_step(seg_t s, bit trk0);
        case (s.direction)
            DIR_IN:
            begin
                dir_pin = 1'b0;
                if (head_pos >= cfg.track_count) begin
                    hit_max = 1'b1;
                    limit_halt();
                end else begin
                    head_pos++;
                    pulse_high = 1'b1;
                    step_pin   = 1'b0;
                end
            end
            DIR_OUT:
            begin
                dir_pin = 1'b1;
                if (head_pos == 0 || trk0) begin
                    hit_min = 1'b1;
                    limit_halt();
                end else begin
                    head_pos--;
                    pulse_high = 1'b1;
                    step_pin   = 1'b0;
                end
            end
            DIR_AUTO:
            begin
                if (head_pos >= cfg.track_count) begin
                    bounce_out = 1'b1;
                    dir_pin    = 1'b1;
                end else if (head_pos == 0) begin
                    bounce_out = 1'b0;
                    dir_pin    = 1'b0;
                end
                if (bounce_out) begin
                    if (head_pos > 0)
                        head_pos--;
                end else if (head_pos < 255) begin
                    head_pos++;
                end
                pulse_high = 1'b1;
                step_pin   = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // Advance playback by one tick
    function automatic void tick_play(bit trk0);
        seg_t s;
        int   len;
        len = active_len();
        if (!play_on)
            return;
        if (seg_pos >= len) begin
            end_of_pass();
            return;
        end
        s = seg_plan[seg_pos];
        tick_cnt++;
        if (!pulse_high) begin
            if (tick_cnt >= int'(s.low_time) * TICKS || advance_due) begin
                advance_due = 1'b0;
                step_cnt++;
                if (step_cnt > int'(s.steps)) begin
                    step_cnt = 0;
                    seg_pos++;
                    if (seg_pos < len) begin
                        advance_due = 1'b1;
                        motor_pin   = !seg_plan[seg_pos].spindle_en;
                    end else begin
                        end_of_pass();
                    end
                end else if (s.high_time > 0) begin
                    fire_step(s, trk0);
                    if (trk0 && s.direction == DIR_AUTO && !cfg.test_mode)
                        head_pos = 0;
                end
                tick_cnt = 0;
            end
        end else if (tick_cnt >= int'(s.high_time) * TICKS) begin
            if (s.low_time > 0)
                step_pin = 1'b1;
            pulse_high = 1'b0;
            tick_cnt   = 0;
        end
    endfunction

    // Apply one request to the predictor and return the status word it yields
    function automatic result_t predict_status(item_t it);
        result_t r;
        case (it.req_type)
            REQ_TICK: tick_play(it.track0_low);
            REQ_LOAD: seg_plan[it.seg_index] = it.seg;
            REQ_START:
            begin
                if (!run_done && active_len() > 0) begin
                    if (cfg.test_mode) begin
                        head_pos   = 0;
                        bounce_out = 1'b0;
                        step_pin   = 1'b1;
                        dir_pin    = 1'b1;
                    end
                    rewind_play();
                    step_cnt  = 0;
                    err_pin   = 1'b0;
                    motor_pin = !seg_plan[0].spindle_en;
                    play_on   = 1'b1;
                end
            end
            REQ_PAUSE: play_on = 1'b0;
            REQ_TOGGLE:
            begin
                if (!cfg.test_mode && active_len() > 0 && (play_on || !run_done))
                    play_on = !play_on;
            end
            REQ_CLEAR:
            begin
                if (run_done) begin
                    play_on  = 1'b0;
                    dir_pin  = 1'b1;
                    step_pin = 1'b1;
                    err_pin  = hit_min || hit_max;
                    rewind_play();
                    head_pos   = 0;
                    step_cnt   = 0;
                    bounce_out = 1'b0;
                    hit_min    = 1'b0;
                    hit_max    = 1'b0;
                    run_done   = 1'b0;
                end
            end
            default: ;
        endcase
        r.step_level      = step_pin;
        r.direction_level = dir_pin;
        r.motor_enable_n  = motor_pin;
        r.error_light     = err_pin;
        r.is_running      = play_on;
        r.head_position   = 8'(head_pos);
        r.min_limit_hit   = hit_min;
        r.max_limit_hit   = hit_max;
        r.test_finished   = run_done;
        r.current_segment = 5'(seg_pos);
        return r;
    endfunction

    function automatic string status_text(result_t r);
        return $sformatf({"step=%0b dir=%0b motor_n=%0b err=%0b run=%0b pos=%0d ",
                          "min=%0b max=%0b done=%0b seg=%0d"},
                         r.step_level, r.direction_level, r.motor_enable_n, r.error_light,
                         r.is_running, r.head_position, r.min_limit_hit, r.max_limit_hit,
                         r.test_finished, r.current_segment);
    endfunction

    function automatic item_t mk_req(logic [2:0] kind, bit trk0, logic [3:0] idx,
                                     logic [15:0] steps, logic [15:0] hi, logic [15:0] lo,
                                     logic [1:0] dir, bit motor);
        item_t it;
        it.req_type       = kind;
        it.track0_low     = trk0;
        it.seg_index      = idx;
        it.seg.steps      = steps;
        it.seg.high_time  = hi;
        it.seg.low_time   = lo;
        it.seg.direction  = dir;
        it.seg.spindle_en = motor;
        return it;
    endfunction

    // Mostly short segments, now and then a full-range field
    function automatic seg_t shaped_segment();
        seg_t s;
        s.steps      = ($urandom_range(0, 29) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        s.high_time  = ($urandom_range(0, 29) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        s.low_time   = ($urandom_range(0, 29) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        s.direction  = 2'($urandom);
        s.spindle_en = 1'($urandom);
        return s;
    endfunction

    // Pick the next random request, steering toward start and clear when stuck
    function automatic item_t next_request();
        item_t it;
        int    r;
        it = mk_req(REQ_TICK, ($urandom_range(0, 9) == 0), 4'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 2'($urandom), 1'($urandom));
        r = $urandom_range(0, 99);
        if (run_done && r < 30)
            it.req_type = REQ_CLEAR;
        else if (!play_on && r < 20)
            it.req_type = REQ_START;
        else if (r < 66)
            it.req_type = REQ_TICK;
        else if (r < 74) begin
            it.req_type = REQ_LOAD;
            it.seg      = shaped_segment();
        end else if (r < 81)
            it.req_type = REQ_START;
        else if (r < 85)
            it.req_type = REQ_PAUSE;
        else if (r < 90)
            it.req_type = REQ_TOGGLE;
        else if (r < 96)
            it.req_type = REQ_CLEAR;
        else
            it.req_type = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
        return it;
    endfunction

    // Offer one request and hold it until accepted; returns at a falling edge
    task automatic send_request(item_t it, bit pinned, result_t pinned_status);
        pinned_q.push_back('{pinned, pinned_status});
        s_tuser  <= it.req_type;
        s_tdata  <= {it.seg.spindle_en, it.seg.direction, it.seg.low_time, it.seg.high_time,
                     it.seg.steps, it.seg_index, it.track0_low};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic walk_rows(ref row_t rows [$]);
        foreach (rows[i])
            send_request(rows[i].req, rows[i].pinned, rows[i].status);
    endtask

    // Drop valid and wait until every status word has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (status_due.size() != 0 || pinned_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write all four registers back to back over APB
    task automatic program_regs(logic [7:0] trk, logic [4:0] len, bit lp, bit tm);
        logic [1:0]  reg_order [4];
        logic [31:0] vals [4];
        reg_order = '{REG_TRACK_COUNT, REG_SEQ_LENGTH, REG_LOOP_ENABLE, REG_TEST_MODE};
        vals[0] = {24'd0, trk};
        vals[1] = {27'd0, len};
        vals[2] = {31'd0, lp};
        vals[3] = {31'd0, tm};
        for (int i = 0; i < 4; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {reg_order[i], 2'b00};
            pwdata  <= vals[i];
            @(negedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            case (reg_order[i])
                REG_TRACK_COUNT: cfg.track_count     = vals[i][7:0];
                REG_SEQ_LENGTH:  cfg.sequence_length = vals[i][4:0];
                REG_LOOP_ENABLE: cfg.loop_enable     = vals[i][0];
                REG_TEST_MODE:   cfg.test_mode       = vals[i][0];
                default: ;
            endcase
            reg_writes++;
            @(negedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Predict on every accepted request, check every accepted status word
    always @(posedge clk) begin : scoreboard
        item_t   seen;
        result_t want, got;
        pin_t    pin;
        if (rst_n && s_tvalid && s_tready) begin
            seen.req_type       = s_tuser;
            seen.track0_low     = s_tdata[0];
            seen.seg_index      = s_tdata[4:1];
            seen.seg.steps      = s_tdata[20:5];
            seen.seg.high_time  = s_tdata[36:21];
            seen.seg.low_time   = s_tdata[52:37];
            seen.seg.direction  = s_tdata[54:53];
            seen.seg.spindle_en = s_tdata[55];
            want = predict_status(seen);
            pin  = pinned_q.pop_front();
            if (pin.fixed)
                want = pin.status;
            status_due.push_back(want);
            requests_in++;
        end
        if (rst_n && m_tvalid && m_tready) begin
            got.step_level      = m_tdata[0];
            got.direction_level = m_tdata[1];
            got.motor_enable_n  = m_tdata[2];
            got.error_light     = m_tdata[3];
            got.is_running      = m_tdata[4];
            got.head_position   = m_tdata[12:5];
            got.min_limit_hit   = m_tdata[13];
            got.max_limit_hit   = m_tdata[14];
            got.test_finished   = m_tdata[15];
            got.current_segment = m_tdata[20:16];
            words_out++;
            if (status_due.size() == 0) begin
                if (fault_count < REPORT_MAX)
                    $display("%0t: status word with no request pending: %s",
                             $time, status_text(got));
                fault_count++;
            end else begin
                want = status_due.pop_front();
                if (got !== want) begin
                    if (fault_count < REPORT_MAX) begin
                        $display("%0t: status word %0d mismatch", $time, words_out);
                        $display("    expected %s", status_text(want));
                        $display("    actual   %s", status_text(got));
                    end
                    fault_count++;
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request
    initial begin : receiver
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end else if (rx_gap_pct != 0 && $urandom_range(0, 99) < rx_gap_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end else begin
                m_tready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    // End the run when no handshake of any kind completes for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d status words outstanding",
                 QUIET_LIMIT, status_due.size());
        $display("** stepper_segment_sequencer: FAILED **");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] trk;
        logic [4:0] len;
        bit         loop_plan [PHASES];
        bit         test_plan [PHASES];
        int         tx_plan [PHASES];
        int         rx_plan [PHASES];
        item_t      it;

        loop_plan = '{0, 1, 0, 0, 0, 1, 1, 0};
        test_plan = '{0, 1, 1, 1, 1, 0, 0, 1};
        tx_plan   = '{25, 8, 5, 30, 0, 15, 20, 0};
        rx_plan   = '{4, 8, 0, 3, 6, 0, 10, 0};

        // Predictor out of reset
        cfg         = '{TRACK_COUNT_RST, 5'd0, 1'b0, 1'b0};
        play_on     = 1'b0;
        bounce_out  = 1'b0;
        hit_min     = 1'b0;
        hit_max     = 1'b0;
        run_done    = 1'b0;
        step_pin    = 1'b1;
        dir_pin     = 1'b1;
        motor_pin   = 1'b1;
        err_pin     = 1'b0;
        step_cnt    = 0;
        head_pos    = 0;
        rewind_play();
        tx_gap_pct  = 0;
        rx_gap_pct  = 0;

        // Idle requests with length zero leave the reset status untouched
        boot_rows.push_back('{mk_req(REQ_TICK, 1'b1, 4'd0, 16'd0, 16'd0, 16'd0, DIR_IN, 1'b0),
                              1'b1, RESET_STATUS});
        boot_rows.push_back('{mk_req(REQ_START, 1'b0, 4'd0, 16'd0, 16'd0, 16'd0, DIR_IN, 1'b0),
                              1'b1, RESET_STATUS});
        boot_rows.push_back('{mk_req(REQ_TOGGLE, 1'b0, 4'd0, 16'd0, 16'd0, 16'd0, DIR_IN, 1'b0),
                              1'b1, RESET_STATUS});
        boot_rows.push_back('{mk_req(REQ_PAUSE, 1'b0, 4'd0, 16'd0, 16'd0, 16'd0, DIR_IN, 1'b0),
                              1'b1, RESET_STATUS});
        boot_rows.push_back('{mk_req(REQ_CLEAR, 1'b0, 4'd0, 16'd0, 16'd0, 16'd0, DIR_IN, 1'b0),
                              1'b1, RESET_STATUS});
        boot_rows.push_back('{mk_req(REQ_SPARE_B, 1'b1, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                     DIR_NONE, 1'b1), 1'b1, RESET_STATUS});
        // Loads: full-range entry at the top index, then a short four-segment plan
        boot_rows.push_back('{mk_req(REQ_LOAD, 1'b1, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                     DIR_NONE, 1'b1), 1'b1, RESET_STATUS});
        boot_rows.push_back('{mk_req(REQ_LOAD, 1'b0, 4'd0, 16'd2, 16'd0, 16'd1, DIR_IN, 1'b1),
                              1'b1, RESET_STATUS});
        boot_rows.push_back('{mk_req(REQ_LOAD, 1'b0, 4'd1, 16'd1, 16'd1, 16'd1, DIR_NONE, 1'b1),
                              1'b1, RESET_STATUS});
        boot_rows.push_back('{mk_req(REQ_LOAD, 1'b0, 4'd2, 16'd2, 16'd1, 16'd0, DIR_IN, 1'b0),
                              1'b1, RESET_STATUS});
        boot_rows.push_back('{mk_req(REQ_LOAD, 1'b0, 4'd3, 16'd3, 16'd2, 16'd1, DIR_AUTO, 1'b1),
                              1'b1, RESET_STATUS});

        // Play it: silent steps, a no-pulse direction, a held-low pin, then the inward limit
        play_rows.push_back('{mk_req(REQ_START, 1'b0, 4'd0, 16'd0, 16'd0, 16'd0, DIR_IN, 1'b0),
                              1'b0, RESET_STATUS});
        repeat (12)
            play_rows.push_back('{mk_req(REQ_TICK, 1'b0, 4'd0, 16'd0, 16'd0, 16'd0, DIR_IN, 1'b0),
                                  1'b0, RESET_STATUS});
        play_rows.push_back('{mk_req(REQ_CLEAR, 1'b0, 4'd0, 16'd0, 16'd0, 16'd0, DIR_IN, 1'b0),
                              1'b0, RESET_STATUS});
        play_rows.push_back('{mk_req(REQ_TOGGLE, 1'b0, 4'd0, 16'd0, 16'd0, 16'd0, DIR_IN, 1'b0),
                              1'b0, RESET_STATUS});
        play_rows.push_back('{mk_req(REQ_PAUSE, 1'b0, 4'd0, 16'd0, 16'd0, 16'd0, DIR_IN, 1'b0),
                              1'b0, RESET_STATUS});

        // Hold reset, then release it on a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        walk_rows(boot_rows);
        drain();
        program_regs(8'd1, 5'd4, 1'b0, 1'b0);
        walk_rows(play_rows);

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            drain();
            trk = (p == 1) ? 8'd0 : (p == 2) ? 8'd255 : (p == 6) ? TRACK_COUNT_RST :
                  8'($urandom_range(1, 12));
            len = (p == 2) ? 5'd16 : (p == 3) ? 5'd31 : (p == 5) ? 5'd0 :
                  5'($urandom_range(1, 6));
            program_regs(trk, len, loop_plan[p], test_plan[p]);
            tx_gap_pct = tx_plan[p];
            rx_gap_pct = rx_plan[p];
            if (p == 2)
                long_hold_req = 1'b1;
            // Fill the whole table before the first start
            if (p == 0) begin
                for (int i = 0; i < MAX_SEGS; i++) begin
                    it           = mk_req(REQ_LOAD, 1'b0, 4'(i), 16'd0, 16'd0, 16'd0, DIR_IN, 1'b0);
                    it.seg       = shaped_segment();
                    send_request(it, 1'b0, RESET_STATUS);
                end
            end
            repeat (PHASE_REQUESTS) begin
                if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 17)) @(negedge clk);
                end
                send_request(next_request(), 1'b0, RESET_STATUS);
            end
        end

        // Let the last status words come back
        drain();
        repeat (8) @(negedge clk);

        $display("Run: %0d requests, %0d status words, %0d register writes over %0d phases",
                 requests_in, words_out, reg_writes, PHASES + 1);
        $display("Predicted %0d limit stops and %0d test completions; %0d faults",
                 limit_stops, completions, fault_count);
        if (fault_count == 0)
            $display("** stepper_segment_sequencer: PASSED **");
        else
            $display("** stepper_segment_sequencer: FAILED **");
        $finish;
    end

endmodule
